// ===== sv/acs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acs_pkg: shared types and constants of the adaptive candidate selector
// Widths, codes, controller/datapath command and status, config helpers.
// ----------------------------------------------------------------------------
package acs_pkg;

    localparam int MAX_CAND    = 8;
    localparam int NUM_CLASSES = 3;
    localparam int CAND_W      = $clog2(MAX_CAND);
    localparam int CNT_W       = CAND_W + 1;
    localparam int CLS_W       = 2;
    localparam int KIND_W      = 2;
    localparam int COST_W      = 32;
    localparam int ENT_W       = $clog2(MAX_CAND * NUM_CLASSES);
    localparam int GAP_W       = 11;
    localparam int PRIOR_W     = CAND_W + 1;
    localparam int DIV_W       = COST_W + 3;
    localparam int RCP_W       = 40;
    localparam int RCP_HALF    = RCP_W / 2;
    localparam int RCP_SHIFT   = 38;
    localparam int PROD_W      = DIV_W + RCP_HALF;
    localparam int ACC_W       = COST_W + RCP_SHIFT;
    localparam int DIV_STEPS   = 2;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);
    localparam int BAR_W       = COST_W + 2;
    localparam int ADDR_W      = 5;
    localparam int DATA_W      = 32;

    localparam logic [COST_W-1:0]  TRIES       = 32'd3;
    localparam logic [GAP_W-1:0]   RETRY_FIRST = 11'd128;
    localparam logic [GAP_W-1:0]   RETRY_LIMIT = 11'd1024;
    localparam logic [14:0]        MARGIN_NUM  = 15'd31785;
    localparam logic [PRIOR_W-1:0] PRIOR_NONE  = '1;

    // reciprocals scaled by 2^38, exact for the average numerators
    localparam logic [RCP_W-1:0] RCP_DIV1 = 40'h40_0000_0000;
    localparam logic [RCP_W-1:0] RCP_DIV2 = 40'h20_0000_0000;
    localparam logic [RCP_W-1:0] RCP_DIV3 = 40'd91625968982;
    localparam logic [RCP_W-1:0] RCP_DIV5 = 40'd54975581389;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_PICK   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RECORD = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;

    // register indexes
    localparam logic [2:0] REG_FORCED    = 3'd0;
    localparam logic [2:0] REG_FIXED     = 3'd1;
    localparam logic [2:0] REG_GPU_ALLOW = 3'd2;
    localparam logic [2:0] REG_COUNT     = 3'd3;
    localparam logic [2:0] REG_DEF_SING  = 3'd4;
    localparam logic [2:0] REG_DEF_SMALL = 3'd5;
    localparam logic [2:0] REG_DEF_BLOCK = 3'd6;
    localparam logic [2:0] REG_GPU_MASK  = 3'd7;

    typedef struct packed {
        logic [3:0]          forced_candidate;
        logic                fixed_mode;
        logic                gpu_allowed;
        logic [3:0]          candidate_count;
        logic [2:0]          default_single;
        logic [2:0]          default_small;
        logic [2:0]          default_block;
        logic [MAX_CAND-1:0] gpu_mask;
    } cfg_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_FORCED, OP_RES_DEF, OP_PASS, OP_LEAST, OP_RES_ACC,
        OP_DEF_READ, OP_BEST, OP_RES_BEST, OP_RETRY, OP_OLD, OP_OLD_DONE,
        OP_REC_MARGIN, OP_REC_CHK, OP_DIV, OP_REC_WR, OP_OUT_LOAD
    } op_t;

    typedef enum logic [1:0] {
        RD_SCAN, RD_DEF, RD_RB, RD_CAND
    } rd_sel_t;

    typedef struct packed {
        op_t     op;
        rd_sel_t rd_sel;
    } cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              cls_bad;
        logic              forced_ok;
        logic              eff_fixed;
        logic              p_zero;
        logic              scan_done;
        logic              least_take;
        logic              due;
        logic              rec_skip;
        logic              div_done;
        logic              out_free;
    } status_t;

    // candidates in use, saturated
    function automatic logic [CNT_W-1:0] eff_count(input logic [3:0] cnt);
        logic [CNT_W-1:0] r;
        r = (cnt > 4'(MAX_CAND)) ? CNT_W'(MAX_CAND) : CNT_W'(cnt);
        return r;
    endfunction

    // default candidate of a class
    function automatic logic [CAND_W-1:0] eff_default(input cfg_t c,
                                                      input logic [CLS_W-1:0] cls);
        logic [2:0] d;
        d = 3'd0;
        case (cls)
            2'd0:    d = c.default_single;
            2'd1:    d = c.default_small;
            2'd2:    d = c.default_block;
            default: d = 3'd0;
        endcase
        return ({1'b0, d} < eff_count(c.candidate_count)) ? d : '0;
    endfunction

    // accelerator candidates only for classes above zero
    function automatic logic usable(input cfg_t c, input logic [CLS_W-1:0] cls,
                                    input logic [CAND_W-1:0] i);
        return !c.gpu_mask[i] || (c.gpu_allowed && (cls != '0));
    endfunction

endpackage

// ===== sv/acs_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acs_if: item channels of the selector
// Request channel (kind, class, measurement) and result channel.
// ----------------------------------------------------------------------------
interface acs_in_if;
    import acs_pkg::*;
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [CLS_W-1:0]    workload_class;
    logic [CAND_W-1:0]   measured_candidate;
    logic [COST_W-1:0]   measured_cost;

    modport source (output valid, kind, workload_class, measured_candidate,
                    measured_cost, input ready);
    modport sink (input valid, kind, workload_class, measured_candidate,
                  measured_cost, output ready);
endinterface

interface acs_out_if;
    import acs_pkg::*;
    logic              valid;
    logic              ready;
    logic [CAND_W-1:0] chosen_candidate;

    modport source (output valid, chosen_candidate, input ready);
    modport sink (input valid, chosen_candidate, output ready);
endinterface

// ===== sv/adaptive_candidate_selector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adaptive_candidate_selector: per-class execution candidate chooser
// Picks, records and queries candidates with exploration and retry.
// ----------------------------------------------------------------------------
// One item is handled at a time; the next is accepted while a result still
// waits in the output register. A tuned pick runs the one candidate per
// cycle scans (least tried, best, longest unused) over the single
// statistics read port. A record runs the two-step reciprocal multiply of
// the cost average. Statistics clear at reset, no clearing pass is needed.
module adaptive_candidate_selector import acs_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    acs_in_if.sink            req,
    acs_out_if.source         rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    cfg_t    cfg;
    cmd_t    cmd;
    status_t status;
    logic    in_ready;
    logic    out_valid;
    logic [CAND_W-1:0] out_data;

    assign req.ready            = in_ready;
    assign rsp.valid            = out_valid;
    assign rsp.chosen_candidate = out_data;

    acs_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    acs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    acs_dp u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg                (cfg),
        .cmd                (cmd),
        .kind               (req.kind),
        .workload_class     (req.workload_class),
        .measured_candidate (req.measured_candidate),
        .measured_cost      (req.measured_cost),
        .out_ready          (rsp.ready),
        .out_valid          (out_valid),
        .chosen_candidate   (out_data),
        .status             (status)
    );

    // one item in flight: no transfer right after a transfer
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("input taken while an item is in flight");

    // a result always names a candidate in use or candidate zero
    a_cand_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.chosen_candidate == '0)
                      || ({1'b0, rsp.chosen_candidate} < eff_count(cfg.candidate_count)))
        else $error("result names a candidate not in use");

endmodule

// ===== sv/acs_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acs_regs: configuration register file
// APB-style write/read of the eight tuning registers.
// ----------------------------------------------------------------------------
module acs_regs import acs_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t       cfg_reg;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg                  <= '0;
            cfg_reg.forced_candidate <= 4'hF;
            cfg_reg.candidate_count  <= 4'd1;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_FORCED:    cfg_reg.forced_candidate <= pwdata[3:0];
                REG_FIXED:     cfg_reg.fixed_mode       <= pwdata[0];
                REG_GPU_ALLOW: cfg_reg.gpu_allowed      <= pwdata[0];
                REG_COUNT:     cfg_reg.candidate_count  <= pwdata[3:0];
                REG_DEF_SING:  cfg_reg.default_single   <= pwdata[2:0];
                REG_DEF_SMALL: cfg_reg.default_small    <= pwdata[2:0];
                REG_DEF_BLOCK: cfg_reg.default_block    <= pwdata[2:0];
                REG_GPU_MASK:  cfg_reg.gpu_mask         <= pwdata[MAX_CAND-1:0];
                default:       ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        prdata = '0;
        unique case (reg_idx)
            REG_FORCED:    prdata = DATA_W'(cfg_reg.forced_candidate);
            REG_FIXED:     prdata = DATA_W'(cfg_reg.fixed_mode);
            REG_GPU_ALLOW: prdata = DATA_W'(cfg_reg.gpu_allowed);
            REG_COUNT:     prdata = DATA_W'(cfg_reg.candidate_count);
            REG_DEF_SING:  prdata = DATA_W'(cfg_reg.default_single);
            REG_DEF_SMALL: prdata = DATA_W'(cfg_reg.default_small);
            REG_DEF_BLOCK: prdata = DATA_W'(cfg_reg.default_block);
            REG_GPU_MASK:  prdata = DATA_W'(cfg_reg.gpu_mask);
            default:       prdata = '0;
        endcase
    end

endmodule

// ===== sv/acs_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acs_dp: selector datapath
// Per-class statistics, candidate scan unit, margin multiplier, two-step
// reciprocal multiplier for the cost average and the result register.
// ----------------------------------------------------------------------------
module acs_dp import acs_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  cmd_t              cmd,
    input  logic [KIND_W-1:0] kind,
    input  logic [CLS_W-1:0]  workload_class,
    input  logic [CAND_W-1:0] measured_candidate,
    input  logic [COST_W-1:0] measured_cost,
    input  logic              out_ready,
    output logic              out_valid,
    output logic [CAND_W-1:0] chosen_candidate,
    output status_t           status
);

    localparam int ENTRIES = MAX_CAND * NUM_CLASSES;

    // latched item
    logic [KIND_W-1:0] kind_reg;
    logic [CLS_W-1:0]  cls_reg;
    logic [CAND_W-1:0] cand_reg;
    logic [COST_W-1:0] cost_reg;

    // statistics
    logic [COST_W-1:0]  avg_mem  [ENTRIES];
    logic [COST_W-1:0]  try_mem  [ENTRIES];
    logic [COST_W-1:0]  last_mem [ENTRIES];
    logic [COST_W-1:0]  pass_mem  [NUM_CLASSES];
    logic [COST_W-1:0]  due_mem   [NUM_CLASSES];
    logic [GAP_W-1:0]   gap_mem   [NUM_CLASSES];
    logic [PRIOR_W-1:0] prior_mem [NUM_CLASSES];
    logic [CAND_W-1:0]  tried_mem [NUM_CLASSES];

    // scan and working registers
    logic [CNT_W-1:0]  idx_reg;
    logic              found_reg;
    logic [CAND_W-1:0] acc_idx_reg;
    logic [COST_W-1:0] acc_val_reg;
    logic [BAR_W-1:0]  bar_reg;
    logic [CAND_W-1:0] best_reg;
    logic [COST_W-1:0] p_reg;
    logic [COST_W-1:0] margin_reg;
    logic [CAND_W-1:0] res_reg;
    logic              out_valid_reg;
    logic [CAND_W-1:0] out_data_reg;

    // average divider: numerator times scaled reciprocal
    logic [DIV_W-1:0]     div_num_reg;
    logic [RCP_W-1:0]     div_rcp_reg;
    logic [ACC_W-1:0]     div_acc_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;

    logic [CNT_W-1:0]    eff_n;
    logic                eff_fixed;
    logic                forced_ok;
    logic [CAND_W-1:0]   def_cand;
    logic [CAND_W-1:0]   scan_cand;
    logic [CAND_W-1:0]   rd_cand;
    logic [ENT_W-1:0]    rd_addr;
    logic [COST_W-1:0]   rd_avg;
    logic [COST_W-1:0]   rd_try;
    logic [COST_W-1:0]   rd_last;
    logic                use_scan;
    logic [46:0]         prod;
    logic [COST_W-1:0]   margin_val;
    logic [COST_W-1:0]   pass_cur;
    logic                prior_ok;
    logic [RCP_HALF-1:0] rcp_part;
    logic [PROD_W-1:0]   part_prod;
    logic [ACC_W-1:0]    part_add;
    logic [GAP_W-1:0]    gap_upd;

    // effective configuration
    always_comb
    begin
        eff_n     = eff_count(cfg.candidate_count);
        eff_fixed = cfg.fixed_mode || (eff_n < CNT_W'(2));
        forced_ok = cfg.forced_candidate < eff_n;
        def_cand  = eff_default(cfg, cls_reg);
        scan_cand = idx_reg[CAND_W-1:0];
        use_scan  = usable(cfg, cls_reg, scan_cand);
        pass_cur  = pass_mem[cls_reg];
        prior_ok  = !prior_mem[cls_reg][PRIOR_W-1];
    end

    // statistics read port
    always_comb
    begin
        case (cmd.rd_sel)
            RD_SCAN: rd_cand = scan_cand;
            RD_DEF:  rd_cand = def_cand;
            RD_RB:   rd_cand = prior_mem[cls_reg][CAND_W-1:0];
            RD_CAND: rd_cand = cand_reg;
            default: rd_cand = scan_cand;
        endcase
        rd_addr    = ENT_W'(cls_reg) * ENT_W'(MAX_CAND) + ENT_W'(rd_cand);
        rd_avg     = avg_mem[rd_addr];
        rd_try     = try_mem[rd_addr];
        rd_last    = last_mem[rd_addr];
        prod       = 47'(rd_avg) * 47'(MARGIN_NUM);
        margin_val = prod[46:15];
    end

    // reciprocal product, low half first, then high half
    always_comb
    begin
        rcp_part  = (div_cnt_reg == '0) ? div_rcp_reg[RCP_HALF-1:0]
                                        : div_rcp_reg[RCP_W-1:RCP_HALF];
        part_prod = PROD_W'(div_num_reg) * PROD_W'(rcp_part);
        part_add  = (div_cnt_reg == '0) ? ACC_W'(part_prod)
                                        : {part_prod[ACC_W-RCP_HALF-1:0], {RCP_HALF{1'b0}}};
    end

    // retry gap update
    always_comb
    begin
        gap_upd = RETRY_LIMIT;
        if (best_reg != prior_mem[cls_reg][CAND_W-1:0])
            gap_upd = RETRY_FIRST;
        else if (gap_mem[cls_reg] < RETRY_LIMIT)
            gap_upd = {gap_mem[cls_reg][GAP_W-2:0], 1'b0};
    end

    // status to the controller
    always_comb
    begin
        status.kind       = kind_reg;
        status.cls_bad    = cls_reg >= CLS_W'(NUM_CLASSES);
        status.forced_ok  = forced_ok;
        status.eff_fixed  = eff_fixed;
        status.p_zero     = p_reg == '0;
        status.scan_done  = idx_reg >= eff_n;
        status.least_take = found_reg && (acc_val_reg < TRIES);
        status.due        = p_reg >= due_mem[cls_reg];
        status.rec_skip   = ({1'b0, cand_reg} >= eff_n) || (eff_fixed && !forced_ok)
                            || (pass_cur <= 32'd1);
        status.div_done   = div_cnt_reg == DIV_CNT_W'(DIV_STEPS);
        status.out_free   = !out_valid_reg || out_ready;
    end

    assign out_valid        = out_valid_reg;
    assign chosen_candidate = out_data_reg;

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.op == OP_OUT_LOAD)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_OUT_LOAD)
            out_data_reg <= res_reg;
    end

    // per-class and per-candidate state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int e = 0; e < ENTRIES; e++)
            begin
                avg_mem[e]  <= '0;
                try_mem[e]  <= '0;
                last_mem[e] <= '0;
            end
            for (int k = 0; k < NUM_CLASSES; k++)
            begin
                pass_mem[k]  <= '0;
                due_mem[k]   <= COST_W'(RETRY_FIRST);
                gap_mem[k]   <= RETRY_FIRST;
                prior_mem[k] <= PRIOR_NONE;
                tried_mem[k] <= '0;
            end
        end
        else
        begin
            case (cmd.op)
                OP_FORCED, OP_PASS:
                    pass_mem[cls_reg] <= pass_cur + 32'd1;
                OP_RETRY:
                    if (prior_ok)
                    begin
                        gap_mem[cls_reg]   <= gap_upd;
                        prior_mem[cls_reg] <= PRIOR_NONE;
                    end
                OP_OLD_DONE:
                begin
                    due_mem[cls_reg] <= p_reg + COST_W'(gap_mem[cls_reg]);
                    if (found_reg)
                    begin
                        prior_mem[cls_reg] <= {1'b0, best_reg};
                        tried_mem[cls_reg] <= acc_idx_reg;
                    end
                end
                OP_REC_CHK:
                    if (prior_ok && (cand_reg == tried_mem[cls_reg])
                        && (cost_reg < margin_reg))
                    begin
                        gap_mem[cls_reg]   <= RETRY_FIRST;
                        due_mem[cls_reg]   <= pass_cur + COST_W'(RETRY_FIRST);
                        prior_mem[cls_reg] <= PRIOR_NONE;
                    end
                OP_REC_WR:
                begin
                    avg_mem[rd_addr]  <= div_acc_reg[ACC_W-1:RCP_SHIFT];
                    try_mem[rd_addr]  <= (&rd_try) ? rd_try : rd_try + 32'd1;
                    last_mem[rd_addr] <= pass_cur;
                end
                default: ;
            endcase
        end
    end

    // control part of the scan
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg     <= '0;
            found_reg   <= 1'b0;
            div_cnt_reg <= '0;
        end
        else
        begin
            case (cmd.op)
                OP_PASS, OP_DEF_READ, OP_RETRY:
                begin
                    idx_reg   <= '0;
                    found_reg <= 1'b0;
                end
                OP_LEAST:
                begin
                    idx_reg <= idx_reg + CNT_W'(1);
                    if (use_scan && (!found_reg || rd_try < acc_val_reg))
                        found_reg <= 1'b1;
                end
                OP_OLD:
                begin
                    idx_reg <= idx_reg + CNT_W'(1);
                    if (scan_cand != best_reg && use_scan
                        && (!found_reg || rd_last < acc_val_reg))
                        found_reg <= 1'b1;
                end
                OP_BEST:     idx_reg <= idx_reg + CNT_W'(1);
                OP_REC_CHK:  div_cnt_reg <= '0;
                OP_DIV:      div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
                default: ;
            endcase
        end
    end

    // working payload registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                kind_reg <= kind;
                cls_reg  <= workload_class;
                cand_reg <= measured_candidate;
                cost_reg <= measured_cost;
            end
            OP_FORCED:  res_reg <= cfg.forced_candidate[CAND_W-1:0];
            OP_RES_DEF: res_reg <= def_cand;
            OP_PASS:    p_reg   <= pass_cur;
            OP_LEAST:
                if (use_scan && (!found_reg || rd_try < acc_val_reg))
                begin
                    acc_idx_reg <= scan_cand;
                    acc_val_reg <= rd_try;
                end
            OP_RES_ACC: res_reg <= acc_idx_reg;
            OP_DEF_READ:
            begin
                best_reg <= def_cand;
                bar_reg  <= (rd_try >= TRIES) ? BAR_W'(margin_val)
                                              : {2'b10, {COST_W{1'b0}}};
            end
            OP_BEST:
                if (scan_cand != def_cand && use_scan && rd_try >= TRIES
                    && BAR_W'(rd_avg) < bar_reg)
                begin
                    best_reg <= scan_cand;
                    bar_reg  <= BAR_W'(rd_avg);
                end
            OP_RES_BEST: res_reg <= best_reg;
            OP_OLD:
                if (scan_cand != best_reg && use_scan
                    && (!found_reg || rd_last < acc_val_reg))
                begin
                    acc_idx_reg <= scan_cand;
                    acc_val_reg <= rd_last;
                end
            OP_OLD_DONE: res_reg <= found_reg ? acc_idx_reg : best_reg;
            OP_REC_MARGIN: margin_reg <= margin_val;
            OP_REC_CHK:
            begin
                div_acc_reg <= '0;
                if (rd_try == '0)
                begin
                    div_num_reg <= DIV_W'(cost_reg);
                    div_rcp_reg <= RCP_DIV1;
                end
                else if (rd_try == 32'd1)
                begin
                    div_num_reg <= DIV_W'(rd_avg) + DIV_W'(cost_reg);
                    div_rcp_reg <= RCP_DIV2;
                end
                else if (rd_try == 32'd2)
                begin
                    div_num_reg <= (DIV_W'(rd_avg) << 1) + DIV_W'(cost_reg);
                    div_rcp_reg <= RCP_DIV3;
                end
                else
                begin
                    div_num_reg <= (DIV_W'(rd_avg) << 2) + DIV_W'(cost_reg);
                    div_rcp_reg <= RCP_DIV5;
                end
            end
            OP_DIV:
                div_acc_reg <= div_acc_reg + part_add;
            default: ;
        endcase
    end

endmodule

// ===== sv/acs_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acs_ctrl: selector sequencer
// Walks one item through the pick, record or query steps.
// ----------------------------------------------------------------------------
module acs_ctrl import acs_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [10:0] {
        S_IDLE     = 11'b000_0000_0001,
        S_DISPATCH = 11'b000_0000_0010,
        S_PICK_P   = 11'b000_0000_0100,
        S_LEAST    = 11'b000_0000_1000,
        S_BEST     = 11'b000_0001_0000,
        S_DUE      = 11'b000_0010_0000,
        S_OLD      = 11'b000_0100_0000,
        S_REC_RB   = 11'b000_1000_0000,
        S_REC_CHK  = 11'b001_0000_0000,
        S_DIV      = 11'b010_0000_0000,
        S_OUT      = 11'b100_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = state_reg == S_IDLE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // next state and datapath command
    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        cmd.rd_sel = RD_SCAN;
        unique case (state_reg)
            S_IDLE:
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_DISPATCH;
                end
            S_DISPATCH:
                if (status.cls_bad)
                    state_next = S_IDLE;
                else if (status.kind == KIND_PICK)
                begin
                    if (status.forced_ok)
                    begin
                        cmd.op     = OP_FORCED;
                        state_next = S_OUT;
                    end
                    else if (status.eff_fixed)
                    begin
                        cmd.op     = OP_RES_DEF;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        cmd.op     = OP_PASS;
                        state_next = S_PICK_P;
                    end
                end
                else if (status.kind == KIND_RECORD)
                    state_next = status.rec_skip ? S_IDLE : S_REC_RB;
                else if (status.kind == KIND_QUERY)
                begin
                    cmd.op     = OP_DEF_READ;
                    cmd.rd_sel = RD_DEF;
                    state_next = S_BEST;
                end
                else
                    state_next = S_IDLE;
            S_PICK_P:
                if (status.p_zero)
                begin
                    cmd.op     = OP_RES_DEF;
                    state_next = S_OUT;
                end
                else
                    state_next = S_LEAST;
            S_LEAST:
                if (!status.scan_done)
                    cmd.op = OP_LEAST;
                else if (status.least_take)
                begin
                    cmd.op     = OP_RES_ACC;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.op     = OP_DEF_READ;
                    cmd.rd_sel = RD_DEF;
                    state_next = S_BEST;
                end
            S_BEST:
                if (!status.scan_done)
                    cmd.op = OP_BEST;
                else if (status.kind == KIND_QUERY)
                begin
                    cmd.op     = OP_RES_BEST;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.op     = OP_RETRY;
                    state_next = S_DUE;
                end
            S_DUE:
                if (status.due)
                    state_next = S_OLD;
                else
                begin
                    cmd.op     = OP_RES_BEST;
                    state_next = S_OUT;
                end
            S_OLD:
                if (!status.scan_done)
                    cmd.op = OP_OLD;
                else
                begin
                    cmd.op     = OP_OLD_DONE;
                    state_next = S_OUT;
                end
            S_REC_RB:
            begin
                cmd.op     = OP_REC_MARGIN;
                cmd.rd_sel = RD_RB;
                state_next = S_REC_CHK;
            end
            S_REC_CHK:
            begin
                cmd.op     = OP_REC_CHK;
                cmd.rd_sel = RD_CAND;
                state_next = S_DIV;
            end
            S_DIV:
                if (!status.div_done)
                    cmd.op = OP_DIV;
                else
                begin
                    cmd.op     = OP_REC_WR;
                    cmd.rd_sel = RD_CAND;
                    state_next = S_IDLE;
                end
            S_OUT:
                if (status.out_free)
                begin
                    cmd.op     = OP_OUT_LOAD;
                    state_next = S_IDLE;
                end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

// ===== test/tb_adaptive_candidate_selector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_adaptive_candidate_selector: self-checking bench of the candidate selector
// Drives pick, record and query items over the request channel, programs the
// registers over APB between phases, and checks every result against an
// in-bench prediction of the selection, exploration and retry behavior.
// ----------------------------------------------------------------------------
module tb_adaptive_candidate_selector;
    import acs_pkg::*;

    localparam int IDLE_LIMIT  = 6000;
    localparam int SETTLE_CYC  = 60;
    localparam int NC          = NUM_CLASSES;
    localparam int NK          = MAX_CAND;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    acs_in_if  req ();
    acs_out_if rsp ();

    adaptive_candidate_selector u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req.sink),
        .rsp     (rsp.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // mirrored registers
    logic [3:0] m_forced;
    logic       m_fixed;
    logic       m_gpu_ok;
    logic [3:0] m_count;
    logic [2:0] m_def [NC];
    logic [7:0] m_mask;

    // mirrored statistics
    logic [31:0] m_avg   [NC][NK];
    logic [31:0] m_tries [NC][NK];
    logic [31:0] m_last  [NC][NK];
    logic [31:0] m_pass  [NC];
    logic [31:0] m_due   [NC];
    logic [31:0] m_gap   [NC];
    int          m_prior [NC];
    int          m_tried [NC];

    logic [CAND_W-1:0] pending_choice [$];
    int src_idle;
    int snk_stall;
    int mismatches;
    int results_seen;
    int picks_sent;
    int records_sent;
    int queries_sent;
    int idle_cycles;
    logic [CAND_W-1:0] last_choice;
    logic              last_had_result;

    // ------------------------------------------------------------------
    // selection prediction
    // ------------------------------------------------------------------
    function automatic int eff_cnt();
        return (m_count > 4'd8) ? 8 : int'(m_count);
    endfunction

    function automatic bit eff_fix();
        return m_fixed || (eff_cnt() < 2);
    endfunction

    function automatic int eff_frc();
        if (m_forced >= 4'd8 || int'(m_forced) >= eff_cnt())
            return -1;
        return int'(m_forced);
    endfunction

    function automatic int eff_def(int cls);
        return (int'(m_def[cls]) < eff_cnt()) ? int'(m_def[cls]) : 0;
    endfunction

    function automatic bit can_use(int cls, int i);
        return !m_mask[i] || (m_gpu_ok && cls > 0);
    endfunction

    function automatic logic [63:0] margin_of(logic [31:0] c);
        return (64'(c) * 64'd31785) >> 15;
    endfunction

    function automatic int best_cand(int cls);
        int d;
        int b;
        logic [63:0] bar;
        d = eff_def(cls);
        b = d;
        bar = (m_tries[cls][d] >= 3) ? margin_of(m_avg[cls][d]) : 64'h2_0000_0000;
        for (int i = 0; i < eff_cnt(); i++)
            if (i != d && can_use(cls, i) && m_tries[cls][i] >= 3 &&
                64'(m_avg[cls][i]) < bar)
            begin
                b = i;
                bar = 64'(m_avg[cls][i]);
            end
        return b;
    endfunction

    function automatic int pick_cand(int cls);
        int n;
        int least;
        int b;
        int old;
        logic [31:0] p;
        n = eff_cnt();
        least = -1;
        old = -1;
        if (eff_frc() >= 0)
        begin
            m_pass[cls]++;
            return eff_frc();
        end
        if (eff_fix())
            return eff_def(cls);
        p = m_pass[cls];
        m_pass[cls]++;
        if (p < 1)
            return eff_def(cls);
        for (int i = 0; i < n; i++)
            if (can_use(cls, i) && (least < 0 || m_tries[cls][i] < m_tries[cls][least]))
                least = i;
        if (least >= 0 && m_tries[cls][least] < 3)
            return least;
        b = best_cand(cls);
        if (m_prior[cls] >= 0)
        begin
            if (b != m_prior[cls])
                m_gap[cls] = 128;
            else
                m_gap[cls] = (m_gap[cls] < 1024) ? 2 * m_gap[cls] : 1024;
            m_prior[cls] = -1;
        end
        if (p >= m_due[cls])
        begin
            for (int i = 0; i < n; i++)
                if (i != b && can_use(cls, i) &&
                    (old < 0 || m_last[cls][i] < m_last[cls][old]))
                    old = i;
            m_due[cls] = p + m_gap[cls];
            if (old >= 0)
            begin
                m_prior[cls] = b;
                m_tried[cls] = old;
                return old;
            end
        end
        return b;
    endfunction

    function automatic void record_cost(int cls, int cand, logic [31:0] x);
        int rb;
        logic [31:0] n;
        logic [63:0] c;
        rb = m_prior[cls];
        n = m_tries[cls][cand];
        c = 64'(m_avg[cls][cand]);
        if ((eff_fix() && eff_frc() < 0) || m_pass[cls] <= 1)
            return;
        if (rb >= 0 && cand == m_tried[cls] && 64'(x) < margin_of(m_avg[cls][rb]))
        begin
            m_gap[cls] = 128;
            m_due[cls] = m_pass[cls] + 128;
            m_prior[cls] = -1;
        end
        if (n == 0)
            c = 64'(x);
        else if (n < 3)
            c = (c * 64'(n) + 64'(x)) / (64'(n) + 64'd1);
        else
            c = (64'd4 * c + 64'(x)) / 64'd5;
        m_avg[cls][cand] = c[31:0];
        if (n != 32'hFFFF_FFFF)
            m_tries[cls][cand] = n + 1;
        m_last[cls][cand] = m_pass[cls];
    endfunction

    // apply one accepted item to the mirror, queue its result if any
    function automatic void predict_item(logic [1:0] kind, logic [1:0] cls,
                                         logic [2:0] cand, logic [31:0] cost);
        last_had_result = 1'b0;
        if (int'(cls) >= NC)
            return;
        if (kind == KIND_PICK)
        begin
            last_choice = CAND_W'(pick_cand(int'(cls)));
            last_had_result = 1'b1;
        end
        else if (kind == KIND_QUERY)
        begin
            last_choice = CAND_W'(best_cand(int'(cls)));
            last_had_result = 1'b1;
        end
        else if (kind == KIND_RECORD && int'(cand) < eff_cnt())
            record_cost(int'(cls), int'(cand), cost);
        if (last_had_result)
            pending_choice.push_back(last_choice);
    endfunction

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------
    task automatic send_item(logic [1:0] kind, logic [1:0] cls, logic [2:0] cand,
                             logic [31:0] cost);
        while ($urandom_range(99) < src_idle)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid              <= 1'b1;
        req.kind               <= kind;
        req.workload_class     <= cls;
        req.measured_candidate <= cand;
        req.measured_cost      <= cost;
        do
            @(posedge clk);
        while (!req.ready);
        predict_item(kind, cls, cand, cost);
        if (kind == KIND_PICK)
            picks_sent++;
        else if (kind == KIND_RECORD)
            records_sent++;
        else
            queries_sent++;
    endtask

    // wait for all results, then let a record still in flight finish
    task automatic drain();
        req.valid <= 1'b0;
        while (pending_choice.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_FORCED:    m_forced = val[3:0];
            REG_FIXED:     m_fixed  = val[0];
            REG_GPU_ALLOW: m_gpu_ok = val[0];
            REG_COUNT:     m_count  = val[3:0];
            REG_DEF_SING:  m_def[0] = val[2:0];
            REG_DEF_SMALL: m_def[1] = val[2:0];
            REG_DEF_BLOCK: m_def[2] = val[2:0];
            default:       m_mask   = val[7:0];
        endcase
    endtask

    task automatic setup(logic [3:0] forced, logic fixed, logic gpu_ok, logic [3:0] cnt,
                         logic [2:0] d0, logic [2:0] d1, logic [2:0] d2, logic [7:0] mask);
        drain();
        write_reg(REG_FORCED, 32'(forced));
        write_reg(REG_FIXED, 32'(fixed));
        write_reg(REG_GPU_ALLOW, 32'(gpu_ok));
        write_reg(REG_COUNT, 32'(cnt));
        write_reg(REG_DEF_SING, 32'(d0));
        write_reg(REG_DEF_SMALL, 32'(d1));
        write_reg(REG_DEF_BLOCK, 32'(d2));
        write_reg(REG_GPU_MASK, 32'(mask));
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_reset_state();
        // single candidate after reset: fixed, default zero
        send_item(KIND_PICK, 2'd0, 3'd0, 32'd0);
        send_item(KIND_QUERY, 2'd2, 3'd0, 32'd0);
        send_item(KIND_RECORD, 2'd1, 3'd0, 32'd500);
    endtask

    task automatic test_open_cases();
        setup(4'hF, 1'b0, 1'b1, 4'd15, 3'd7, 3'd3, 3'd5, 8'hFF);
        send_item(2'd3, 2'd0, 3'd7, 32'hFFFF_FFFF);     // unknown kind
        send_item(KIND_PICK, 2'd3, 3'd0, 32'd0);        // class out of range
        send_item(KIND_QUERY, 2'd3, 3'd0, 32'd0);
        send_item(KIND_PICK, 2'd1, 3'd0, 32'd0);        // warm-up default
        send_item(KIND_RECORD, 2'd1, 3'd3, 32'd10);     // ignored, one pass only
        send_item(KIND_PICK, 2'd1, 3'd0, 32'd0);
        send_item(KIND_RECORD, 2'd1, 3'd7, 32'hFFFF_FFFF);
        send_item(KIND_RECORD, 2'd1, 3'd0, 32'd0);
        send_item(KIND_PICK, 2'd0, 3'd0, 32'd0);        // class 0 sees mask
        send_item(KIND_PICK, 2'd0, 3'd0, 32'd0);
        send_item(KIND_QUERY, 2'd1, 3'd0, 32'd0);
        // unused candidate record
        setup(4'hF, 1'b0, 1'b0, 4'd4, 3'd7, 3'd7, 3'd7, 8'h00);
        send_item(KIND_RECORD, 2'd1, 3'd6, 32'd1);
        send_item(KIND_PICK, 2'd1, 3'd0, 32'd0);
    endtask

    task automatic test_forced_and_fixed();
        setup(4'd2, 1'b1, 1'b0, 4'd4, 3'd1, 3'd2, 3'd3, 8'h00);
        send_item(KIND_PICK, 2'd2, 3'd0, 32'd0);
        send_item(KIND_RECORD, 2'd2, 3'd2, 32'd700);    // one pass only, ignored; forced learns from the next
        send_item(KIND_PICK, 2'd2, 3'd0, 32'd0);
        send_item(KIND_RECORD, 2'd2, 3'd2, 32'd900);
        setup(4'd7, 1'b1, 1'b0, 4'd4, 3'd1, 3'd2, 3'd3, 8'h00); // forced beyond count
        send_item(KIND_PICK, 2'd2, 3'd0, 32'd0);
        send_item(KIND_RECORD, 2'd2, 3'd1, 32'd5);      // fixed, ignored
        send_item(KIND_QUERY, 2'd2, 3'd0, 32'd0);
        setup(4'hF, 1'b0, 1'b0, 4'd0, 3'd0, 3'd0, 3'd0, 8'h00); // no candidates
        send_item(KIND_PICK, 2'd0, 3'd0, 32'd0);
    endtask

    // pick then record of the picked candidate, with some noise items
    task automatic test_tuning(int items, logic [1:0] cls_hi, int focus);
        logic [31:0] cost;
        logic [1:0]  cls;
        int          sent;
        sent = 0;
        while (sent < items)
        begin
            if ($urandom_range(99) < 12)
            begin
                send_item(2'($urandom_range(3)), 2'($urandom_range(3)),
                          3'($urandom_range(7)), $urandom());
                sent++;
            end
            else
            begin
                cls = (focus >= 0 && $urandom_range(3) != 0) ? 2'(focus)
                                                            : 2'($urandom_range(cls_hi));
                send_item(KIND_PICK, cls, 3'($urandom_range(7)), $urandom());
                if (last_had_result && $urandom_range(9) != 0)
                begin
                    if ($urandom_range(19) == 0)
                        cost = $urandom();
                    else
                        cost = 32'(1000 + 150 * int'(last_choice)) -
                               32'(($urandom_range(1) == 0) ? 600 : 0) *
                               32'(last_choice == 3'd5) + 32'($urandom_range(90));
                    send_item(KIND_RECORD, cls, last_choice, cost);
                    sent++;
                end
                if ($urandom_range(15) == 0)
                begin
                    send_item(KIND_QUERY, cls, 3'd0, 32'd0);
                    sent++;
                end
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        rsp.ready <= ($urandom_range(99) >= snk_stall);
        if (rst_n && rsp.valid && rsp.ready)
        begin
            results_seen++;
            if (pending_choice.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: chosen_candidate=%0d", rsp.chosen_candidate);
            end
            else
            begin
                if (rsp.chosen_candidate !== pending_choice[0])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("chosen_candidate mismatch: expected %0d actual %0d",
                                 pending_choice[0], rsp.chosen_candidate);
                end
                void'(pending_choice.pop_front());
            end
        end
    end

    // watchdog on cycles with no transfer and no register write
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || psel || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n       <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        req.valid   <= 1'b0;
        req.kind    <= KIND_PICK;
        req.workload_class     <= '0;
        req.measured_candidate <= '0;
        req.measured_cost      <= '0;
        picks_sent   = 0;
        records_sent = 0;
        queries_sent = 0;
        src_idle     = 10;
        snk_stall    = 86;
        m_forced = 4'hF;
        m_fixed  = 1'b0;
        m_gpu_ok = 1'b0;
        m_count  = 4'd1;
        m_mask   = 8'h00;
        for (int c = 0; c < NC; c++)
        begin
            m_def[c]   = 3'd0;
            m_pass[c]  = 0;
            m_due[c]   = 128;
            m_gap[c]   = 128;
            m_prior[c] = -1;
            m_tried[c] = 0;
            for (int i = 0; i < NK; i++)
            begin
                m_avg[c][i]   = 0;
                m_tries[c][i] = 0;
                m_last[c][i]  = 0;
            end
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_open_cases();
        test_forced_and_fixed();

        setup(4'hF, 1'b0, 1'b1, 4'd8, 3'd0, 3'd4, 3'd7, 8'h0C);
        test_tuning(120, 2'd2, -1);

        src_idle  = 86;
        snk_stall = 10;
        setup(4'hF, 1'b0, 1'b0, 4'd3, 3'd7, 3'd1, 3'd2, 8'h02);
        test_tuning(100, 2'd2, 1);

        src_idle  = 0;
        snk_stall = 0;
        setup(4'hF, 1'b0, 1'b0, 4'd8, 3'd7, 3'd7, 3'd7, 8'h81);
        test_tuning(200, 2'd2, 2);

        drain();
        $display("covered %0d picks, %0d records, %0d queries or other items",
                 picks_sent, records_sent, queries_sent);
        $display("%0d results checked across forced, fixed, warm-up, explore and retry",
                 results_seen);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
